// File: src/rcbp_pkg.sv
// Shared types and byte codes for the remote command byte parser.
package rcbp_pkg;

	localparam logic [7:0] BYTE_GEAR_HIGH = 8'h58;
	localparam logic [7:0] BYTE_GEAR_LOW  = 8'h59;
	localparam logic [7:0] BYTE_CMD_MIN   = 8'd10;
	localparam logic [7:0] BYTE_FORWARD   = 8'h41;
	localparam logic [7:0] BYTE_BACKWARD  = 8'h45;
	localparam logic [7:0] BYTE_RIGHT_LO  = 8'h42;
	localparam logic [7:0] BYTE_RIGHT_HI  = 8'h44;
	localparam logic [7:0] BYTE_LEFT_LO   = 8'h46;
	localparam logic [7:0] BYTE_LEFT_HI   = 8'h48;
	localparam logic [7:0] BYTE_OPEN      = 8'h7B;
	localparam logic [7:0] BYTE_CLOSE     = 8'h7D;
	localparam logic [7:0] BYTE_SAVE      = 8'h50;
	localparam logic [7:0] BYTE_SKIP_ID   = 8'h23;
	localparam logic [7:0] BYTE_ID_FIRST  = 8'h30;
	localparam logic [7:0] BYTE_ID_LAST   = 8'h35;
	localparam logic [7:0] BYTE_DIGIT_0   = 8'd48;

	localparam logic [1:0] GEAR_HIGH = 2'd1;
	localparam logic [1:0] GEAR_LOW  = 2'd2;

	localparam int ID_INDEX     = 1;
	localparam int MARKER_INDEX = 3;

	typedef struct packed {
		logic       fwd;
		logic       bwd;
		logic       left;
		logic       right;
		logic [1:0] gear;
	} motion_t;

	typedef struct packed {
		logic              gain_valid;
		logic [2:0]        gain_select;
		logic signed [31:0] gain_value;
		logic              save;
	} gain_t;

endpackage

// File: src/rcbp_motion_decode.sv
// Motion flag and speed gear decoder with its command state.
module rcbp_motion_decode
	import rcbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	output motion_t    motion
);

	motion_t state_q;

	always_comb begin
		motion = state_q;
		if (rx_byte == BYTE_GEAR_LOW) motion.gear = GEAR_LOW;
		if (rx_byte == BYTE_GEAR_HIGH) motion.gear = GEAR_HIGH;
		if (rx_byte > BYTE_CMD_MIN) begin
			motion.fwd   = 1'b0;
			motion.bwd   = 1'b0;
			motion.left  = 1'b0;
			motion.right = 1'b0;
			unique case (rx_byte) inside
				BYTE_FORWARD:                  motion.fwd   = 1'b1;
				BYTE_BACKWARD:                 motion.bwd   = 1'b1;
				[BYTE_RIGHT_LO:BYTE_RIGHT_HI]: motion.right = 1'b1;
				[BYTE_LEFT_LO:BYTE_LEFT_HI]:   motion.left  = 1'b1;
				default:                       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{fwd: 1'b0, bwd: 1'b0, left: 1'b0, right: 1'b0, gear: GEAR_LOW};
		end else if (en) begin
			state_q <= motion;
		end
	end

endmodule

// File: src/rcbp_frame_parser.sv
// Tuning frame tracker: index count, id and marker capture, decimal accumulator.
module rcbp_frame_parser
	import rcbp_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	output gain_t      gain
);

	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(BUFFER_DEPTH);
	localparam logic [CNT_W-1:0] ID_C     = CNT_W'(ID_INDEX);
	localparam logic [CNT_W-1:0] MARKER_C = CNT_W'(MARKER_INDEX);
	localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
	localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

	logic               open_q, open_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [7:0]         id_q, id_d;
	logic [7:0]         marker_q, marker_d;
	logic signed [31:0] acc_q, acc_d;
	logic signed [36:0] acc_ext;
	logic signed [36:0] fold;
	logic signed [31:0] fold_sat;

	always_comb begin
		acc_ext = 37'(acc_q);
		fold = (acc_ext <<< 3) + (acc_ext <<< 1)
			+ $signed({29'd0, rx_byte}) - $signed({29'd0, BYTE_DIGIT_0});
		if (fold > SAT_MAX) fold_sat = SAT_MAX[31:0];
		else if (fold < SAT_MIN) fold_sat = SAT_MIN[31:0];
		else fold_sat = fold[31:0];
	end

	always_comb begin
		gain     = '0;
		open_d   = open_q;
		cnt_d    = cnt_q;
		id_d     = id_q;
		marker_d = marker_q;
		acc_d    = acc_q;
		if (rx_byte == BYTE_CLOSE) begin
			if (open_q) begin
				if (marker_q == BYTE_SAVE) begin
					gain.save = 1'b1;
				end else if (id_q != BYTE_SKIP_ID && id_q >= BYTE_ID_FIRST
					&& id_q <= BYTE_ID_LAST) begin
					gain.gain_valid  = 1'b1;
					gain.gain_select = 3'(id_q - BYTE_ID_FIRST);
					gain.gain_value  = acc_q;
				end
			end
			open_d   = 1'b0;
			cnt_d    = '0;
			id_d     = '0;
			marker_d = '0;
			acc_d    = '0;
		end else begin
			if (rx_byte == BYTE_OPEN) open_d = 1'b1;
			if (open_d && cnt_q < DEPTH_C) begin
				if (cnt_q == ID_C) id_d = rx_byte;
				if (cnt_q == MARKER_C) marker_d = rx_byte;
				if (cnt_q >= MARKER_C) acc_d = fold_sat;
				cnt_d = cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			cnt_q    <= '0;
			id_q     <= '0;
			marker_q <= '0;
			acc_q    <= '0;
		end else if (en) begin
			open_q   <= open_d;
			cnt_q    <= cnt_d;
			id_q     <= id_d;
			marker_q <= marker_d;
			acc_q    <= acc_d;
		end
	end

endmodule

// File: src/remote_command_byte_parser_unit.sv
// Top level of the remote command byte parser: input register, decode, result register.
//
//  channel  | dir | beat contents
//  s_axis   | in  | one received byte
//  m_axis   | out | motion flags, gear, gain update, save request (tuser: gain valid)
//
//  One beat per cycle unless m_axis stalls; bytes pass input then result register.
//  The command and frame state update in the cycle a byte moves into the result register.
//  Reset sets the flags and frame state to zero and the gear to low speed.
//  A stalled m_axis holds the result register; the input register fills,
//  then s_axis_tready drops.
module remote_command_byte_parser_unit
	import rcbp_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [0] go_forward, [1] go_backward, [2] turn_left,
	                                    // [3] turn_right, [5:4] speed_gear, [8:6] gain_select,
	                                    // [40:9] gain_value, [41] save_request, [47:42] zero
	output logic        m_axis_tuser    // [0] gain_valid
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv_s2;
	logic       load_s2;
	motion_t    motion;
	gain_t      gain;
	motion_t    motion_s2;
	gain_t      gain_s2;

	assign adv_s2        = !m_axis_tvalid || m_axis_tready;
	assign load_s2       = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) byte_s1 <= s_axis_tdata;
	end

	rcbp_motion_decode u_motion (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (load_s2),
		.rx_byte (byte_s1),
		.motion  (motion)
	);

	rcbp_frame_parser #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (load_s2),
		.rx_byte (byte_s1),
		.gain    (gain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv_s2) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			motion_s2 <= motion;
			gain_s2   <= gain;
		end
	end

	assign m_axis_tdata = {6'd0, gain_s2.save, gain_s2.gain_value, gain_s2.gain_select,
		motion_s2.gear, motion_s2.right, motion_s2.left, motion_s2.bwd, motion_s2.fwd};
	assign m_axis_tuser = gain_s2.gain_valid;

	a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output stall");

	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> m_axis_tvalid)
		else $error("loaded beat lost");

	a_gear_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[5:4] == GEAR_HIGH || m_axis_tdata[5:4] == GEAR_LOW))
		else $error("illegal gear");

	a_gain_save_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser && m_axis_tdata[41]))
		else $error("gain update and save request together");

	a_idle_gain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[40:6] == '0))
		else $error("gain fields not zero without update");

endmodule
